/* rtl/hpd_pkg.sv */
// Shared constants, codes and types of the Huffman pixel decoder.
package hpd_pkg;

    // Default sizing
    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int MAX_CODE_LEN_DEF  = 16;

    // Slots reachable through the 8-bit entry index
    localparam int SLOT_LIMIT = 256;

    // Field widths
    localparam int INDEX_W   = 8;
    localparam int CODE_W    = 16;
    localparam int LENGTH_W  = 5;
    localparam int COLOR_W   = 24;
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int DIM_W     = 13;
    localparam int PIX_W     = 2 * DIM_W;
    localparam int LEN_CMP_W = 6;

    // Bit-serial byte handling
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = 4;

    // Stream and register port widths
    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Input item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    // Register indexes
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    // One code table entry as held in the RAM
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [LENGTH_W-1:0] length;
        logic [COLOR_W-1:0]  color;
    } entry_t;

    // Table write and clear requests
    typedef struct packed {
        logic               clear;
        logic               load;
        logic [INDEX_W-1:0] index;
        entry_t             entry;
    } tbl_ctrl_t;

    // Outcome of one table search
    typedef struct packed {
        logic               done;
        logic               hit;
        logic [COLOR_W-1:0] color;
    } scan_res_t;

endpackage

/* rtl/hpd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module hpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/hpd_cfg.sv */
// Register port: image width and height, and the registered pixel limit.
module hpd_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpd_pkg::APB_AW-1:0] paddr,
    input  logic [hpd_pkg::APB_DW-1:0] pwdata,
    output logic [hpd_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [hpd_pkg::PIX_W-1:0]  limit
);

    logic [hpd_pkg::DIM_W-1:0] width_reg,  width_next;
    logic [hpd_pkg::DIM_W-1:0] height_reg, height_next;
    logic [hpd_pkg::PIX_W-1:0] limit_reg;
    hpd_pkg::reg_idx_t         reg_idx;
    logic                      wr_stb;

    assign pready  = 1'b1;
    assign reg_idx = hpd_pkg::reg_idx_t'(paddr[2]);
    assign wr_stb  = psel && penable && pwrite && pready;

    // Register writes
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr_stb) begin
            case (reg_idx)
                hpd_pkg::REG_WIDTH:  width_next  = pwdata[hpd_pkg::DIM_W-1:0];
                hpd_pkg::REG_HEIGHT: height_next = pwdata[hpd_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= hpd_pkg::DIM_W'(1);
            height_reg <= hpd_pkg::DIM_W'(1);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // Pixel limit, one multiply registered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= hpd_pkg::PIX_W'(1);
        end else begin
            limit_reg <= width_reg * height_reg;
        end
    end

    assign limit = limit_reg;

    // Read back
    always_comb begin
        case (reg_idx)
            hpd_pkg::REG_WIDTH:  prdata = hpd_pkg::APB_DW'(width_reg);
            hpd_pkg::REG_HEIGHT: prdata = hpd_pkg::APB_DW'(height_reg);
            default:             prdata = '0;
        endcase
    end

endmodule

/* rtl/hpd_table.sv */
// Code table store and serial first-match search, one slot per cycle.
module hpd_table #(
    parameter int TABLE_ENTRIES = hpd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LEN  = hpd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hpd_pkg::tbl_ctrl_t                    ctrl,
    input  logic                                  scan_start,
    input  logic [MAX_CODE_LEN-1:0]               acc_bits,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]     acc_len,
    output hpd_pkg::scan_res_t                    res
);

    localparam int SLOTS  = (TABLE_ENTRIES < hpd_pkg::SLOT_LIMIT) ?
                            TABLE_ENTRIES : hpd_pkg::SLOT_LIMIT;
    localparam int AW     = $clog2(SLOTS);
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int ACC_W  = MAX_CODE_LEN;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int WIDE_W = ACC_W + hpd_pkg::CODE_W;
    localparam int ENT_W  = $bits(hpd_pkg::entry_t);
    localparam logic [hpd_pkg::INDEX_W:0] SLOTS_V = (hpd_pkg::INDEX_W + 1)'(SLOTS);

    logic [SLOTS-1:0]    valid_reg;
    logic                busy_reg, busy_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic                chk_valid_reg, chk_valid_next;
    logic                chk_last_reg, chk_last_next;
    logic                in_range;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [ENT_W-1:0]    rd_data;
    hpd_pkg::entry_t     rd_entry;
    logic [WIDE_W-1:0]   code_wide;
    logic [ACC_W-1:0]    code_ext;
    logic [ACC_W-1:0]    len_mask;
    logic                hit;

    // Loads beyond the table are dropped
    assign in_range = {1'b0, ctrl.index} < SLOTS_V;
    assign wr_en    = ctrl.load && in_range;
    assign wr_addr  = ctrl.index[AW-1:0];

    assign rd_addr  = issue_reg[AW-1:0];
    assign rd_en    = busy_reg && (issue_reg < CW'(SLOTS));
    assign rd_entry = hpd_pkg::entry_t'(rd_data);

    hpd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ctrl.entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Valid flags, cleared at once by reset or a clear item
    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Compare the slot just read with the accumulator
    always_comb begin
        code_wide = {{ACC_W{1'b0}}, rd_entry.code};
        code_ext  = code_wide[ACC_W-1:0];
        for (int k = 0; k < ACC_W; k++) begin
            len_mask[k] = LEN_W'(k) < acc_len;
        end
        hit = chk_valid_reg
              && (hpd_pkg::LEN_CMP_W'(rd_entry.length) == hpd_pkg::LEN_CMP_W'(acc_len))
              && ((code_ext & len_mask) == acc_bits);
    end

    // Search sequencer: issue reads in slot order, stop at the first hit
    always_comb begin
        busy_next      = busy_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        chk_valid_next = chk_valid_reg;
        chk_last_next  = chk_last_reg;
        res            = '0;
        res.color      = rd_entry.color;
        if (scan_start) begin
            busy_next  = 1'b1;
            issue_next = '0;
            pend_next  = 1'b0;
        end else if (busy_reg) begin
            pend_next      = rd_en;
            chk_valid_next = rd_en && valid_reg[rd_addr];
            chk_last_next  = issue_reg == CW'(SLOTS - 1);
            if (rd_en) begin
                issue_next = CW'(issue_reg + 1'b1);
            end
            if (pend_reg) begin
                if (hit) begin
                    res.done  = 1'b1;
                    res.hit   = 1'b1;
                    busy_next = 1'b0;
                    pend_next = 1'b0;
                end else if (chk_last_reg) begin
                    res.done  = 1'b1;
                    busy_next = 1'b0;
                    pend_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_last_reg  <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            chk_valid_reg <= chk_valid_next;
            chk_last_reg  <= chk_last_next;
        end
    end

endmodule

/* rtl/huffman_pixel_decoder.sv */
// Huffman pixel decoder top level: bit-serial accumulator, sequencer and output register.
// Table load, clear and unused items are handled directly in the idle state. Each bit of a
// data byte is shifted in, then searched for through the single table RAM read port, one
// slot per cycle over up to S = min(TABLE_ENTRIES, 256) slots, and a hit or code error
// is handed to the output register. Bits after the image is complete are skipped without
// a search. Reset clears the sequencer, accumulator, pixel count and slot valid flags at
// once; table contents are undefined until written, with no clearing pass.
module huffman_pixel_decoder #(
    parameter int TABLE_ENTRIES = hpd_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_LEN  = hpd_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // entry_index[7:0], entry_code[23:8], entry_length[28:24], entry_color[52:29],
    // data_byte[60:53], zero fill [63:61]
    input  logic [hpd_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[1:0]
    input  logic [hpd_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // color[23:0]
    output logic [hpd_pkg::M_TDATA_W-1:0] m_tdata,
    // code_error[0]
    output logic [hpd_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpd_pkg::APB_AW-1:0]    paddr,
    input  logic [hpd_pkg::APB_DW-1:0]    pwdata,
    output logic [hpd_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int ACC_W = MAX_CODE_LEN;
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t                            state_reg, state_next;
    logic [hpd_pkg::BYTE_W-1:0]        byte_reg, byte_next;
    logic [hpd_pkg::BIT_CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [ACC_W-1:0]                  acc_bits_reg, acc_bits_next;
    logic [LEN_W-1:0]                  acc_len_reg, acc_len_next;
    logic [hpd_pkg::PIX_W-1:0]         pix_reg, pix_next;
    logic [hpd_pkg::COLOR_W-1:0]       pend_color_reg, pend_color_next;
    logic                              pend_last_reg, pend_last_next;
    logic                              pend_err_reg, pend_err_next;
    logic                              m_valid_reg, m_valid_next;
    logic [hpd_pkg::COLOR_W-1:0]       m_color_reg, m_color_next;
    logic                              m_last_reg, m_last_next;
    logic                              m_err_reg, m_err_next;
    logic [hpd_pkg::PIX_W-1:0]         limit;
    logic                              image_done;
    logic                              scan_start;
    hpd_pkg::tbl_ctrl_t                tbl_ctrl;
    hpd_pkg::scan_res_t                res;
    hpd_pkg::kind_t                    in_kind;
    logic [hpd_pkg::BYTE_W-1:0]        in_byte;

    // Input item fields
    assign in_kind = hpd_pkg::kind_t'(s_tuser[1:0]);
    assign in_byte = s_tdata[60:53];

    hpd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limit   (limit)
    );

    hpd_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_LEN  (MAX_CODE_LEN)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (tbl_ctrl),
        .scan_start (scan_start),
        .acc_bits   (acc_bits_reg),
        .acc_len    (acc_len_reg),
        .res        (res)
    );

    assign image_done = pix_reg >= limit;
    assign s_tready   = state_reg == ST_IDLE;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        byte_next       = byte_reg;
        bit_cnt_next    = bit_cnt_reg;
        acc_bits_next   = acc_bits_reg;
        acc_len_next    = acc_len_reg;
        pix_next        = pix_reg;
        pend_color_next = pend_color_reg;
        pend_last_next  = pend_last_reg;
        pend_err_next   = pend_err_reg;
        m_valid_next    = m_valid_reg;
        m_color_next    = m_color_reg;
        m_last_next     = m_last_reg;
        m_err_next      = m_err_reg;
        scan_start      = 1'b0;

        tbl_ctrl              = '0;
        tbl_ctrl.index        = s_tdata[7:0];
        tbl_ctrl.entry.code   = s_tdata[23:8];
        tbl_ctrl.entry.length = s_tdata[28:24];
        tbl_ctrl.entry.color  = s_tdata[52:29];

        // Output register empties when taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_kind)
                        hpd_pkg::KIND_CLEAR: begin
                            tbl_ctrl.clear = 1'b1;
                            acc_bits_next  = '0;
                            acc_len_next   = '0;
                            pix_next       = '0;
                        end
                        hpd_pkg::KIND_LOAD: begin
                            tbl_ctrl.load = 1'b1;
                        end
                        hpd_pkg::KIND_DATA: begin
                            byte_next    = in_byte;
                            bit_cnt_next = hpd_pkg::BIT_CNT_W'(hpd_pkg::BITS_PER_BYTE);
                            state_next   = ST_SHIFT;
                        end
                        default: ;
                    endcase
                end
            end
            // Take the next bit, MSB first
            ST_SHIFT: begin
                if (bit_cnt_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    byte_next    = {byte_reg[hpd_pkg::BYTE_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                    if (!image_done) begin
                        acc_bits_next = ACC_W'({acc_bits_reg, byte_reg[hpd_pkg::BYTE_W-1]});
                        acc_len_next  = acc_len_reg + 1'b1;
                        scan_start    = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            // Wait for the table search
            ST_SCAN: begin
                if (res.done) begin
                    if (res.hit) begin
                        pend_color_next = res.color;
                        pend_last_next  = hpd_pkg::PIX_W'(pix_reg + 1'b1) == limit;
                        pend_err_next   = 1'b0;
                        pix_next        = hpd_pkg::PIX_W'(pix_reg + 1'b1);
                        acc_bits_next   = '0;
                        acc_len_next    = '0;
                        state_next      = ST_EMIT;
                    end else if (acc_len_reg >= LEN_W'(MAX_CODE_LEN)) begin
                        pend_color_next = '0;
                        pend_last_next  = 1'b0;
                        pend_err_next   = 1'b1;
                        acc_bits_next   = '0;
                        acc_len_next    = '0;
                        state_next      = ST_EMIT;
                    end else begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            // Hand the result to the output register once it is free
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_color_next = pend_color_reg;
                    m_last_next  = pend_last_reg;
                    m_err_next   = pend_err_reg;
                    state_next   = ST_SHIFT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            bit_cnt_reg  <= '0;
            acc_bits_reg <= '0;
            acc_len_reg  <= '0;
            pix_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            acc_bits_reg <= acc_bits_next;
            acc_len_reg  <= acc_len_next;
            pix_reg      <= pix_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        pend_color_reg <= pend_color_next;
        pend_last_reg  <= pend_last_next;
        pend_err_reg   <= pend_err_next;
        m_color_reg    <= m_color_next;
        m_last_reg     <= m_last_next;
        m_err_reg      <= m_err_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_color_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_err_reg;

    // Error items carry no colour and never end the image
    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tlast))
        else $error("error item with colour or last flag");

    // Search results arrive only while the sequencer waits for them
    a_res_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |-> (state_reg == ST_SCAN))
        else $error("table result outside search");

    // A search start always moves the sequencer into the wait state
    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_start |=> (state_reg == ST_SCAN))
        else $error("search started without waiting");

    // A search always runs on at least one gathered bit
    a_scan_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (acc_len_reg != '0))
        else $error("search with empty accumulator");

endmodule

/* test/tb_huffman_pixel_decoder.sv */
// Self-checking testbench for the Huffman pixel decoder: stream stimulus, APB set-up, scoreboard.
`timescale 1ns / 1ps

module tb_huffman_pixel_decoder;
    import hpd_pkg::*;

    localparam int DRAIN_CYCLES = 8 * (SLOT_LIMIT + 3) + 64;
    localparam int RANDOM_ITEMS = 240;

    // One expected result item
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               last;
        logic               err;
    } pixel_t;

    // Tracks table, accumulator and pixel count; holds the pixels still owed by the block
    class pixel_tracker;
        logic [CODE_W-1:0]   slot_code  [SLOT_LIMIT];
        logic [LENGTH_W-1:0] slot_len   [SLOT_LIMIT];
        logic [COLOR_W-1:0]  slot_color [SLOT_LIMIT];
        bit                  slot_valid [SLOT_LIMIT];
        logic [CODE_W-1:0]   acc_bits;
        int unsigned         acc_len;
        int unsigned         emitted;
        int unsigned         img_w;
        int unsigned         img_h;
        pixel_t              owed_pixels [$];
        int unsigned         mismatches;

        function new();
            wipe();
            img_w      = 1;
            img_h      = 1;
            mismatches = 0;
        endfunction

        function void wipe();
            foreach (slot_valid[i]) slot_valid[i] = 1'b0;
            acc_bits = '0;
            acc_len  = 0;
            emitted  = 0;
        endfunction

        function int unsigned outstanding();
            return owed_pixels.size();
        endfunction

        function void set_dim(reg_idx_t r, logic [APB_DW-1:0] v);
            case (r)
                REG_WIDTH:  img_w = v[DIM_W-1:0];
                REG_HEIGHT: img_h = v[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        // Note an accepted input item and queue the pixels it decodes
        function void absorb_item(logic [S_TUSER_W-1:0] kind, logic [S_TDATA_W-1:0] word);
            kind_t             k;
            logic [BYTE_W-1:0] bv;
            logic [CODE_W-1:0] cmask;
            int unsigned       limit;
            int                hit;
            pixel_t            px;
            int unsigned       idx;
            k = kind_t'(kind);
            case (k)
                KIND_CLEAR: wipe();
                KIND_LOAD: begin
                    idx             = word[7:0];
                    slot_code[idx]  = word[23:8];
                    slot_len[idx]   = word[28:24];
                    slot_color[idx] = word[52:29];
                    slot_valid[idx] = 1'b1;
                end
                KIND_DATA: begin
                    bv    = word[60:53];
                    limit = img_w * img_h;
                    for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
                        if (emitted >= limit) continue;
                        acc_bits = {acc_bits[CODE_W-2:0], bv[b]};
                        acc_len++;
                        cmask = CODE_W'((33'd1 << acc_len) - 1);
                        hit   = -1;
                        for (int i = 0; i < SLOT_LIMIT && hit < 0; i++) begin
                            if (slot_valid[i] && slot_len[i] == acc_len &&
                                (slot_code[i] & cmask) == acc_bits)
                                hit = i;
                        end
                        if (hit >= 0) begin
                            emitted++;
                            px.color = slot_color[hit];
                            px.last  = (emitted == limit);
                            px.err   = 1'b0;
                            owed_pixels.insert(owed_pixels.size(), px);
                            acc_bits = '0;
                            acc_len  = 0;
                        end else if (acc_len >= MAX_CODE_LEN_DEF) begin
                            px = '{color: '0, last: 1'b0, err: 1'b1};
                            owed_pixels.insert(owed_pixels.size(), px);
                            acc_bits = '0;
                            acc_len  = 0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task report(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare an accepted result item with the oldest owed pixel
        task check_pixel(logic [COLOR_W-1:0] color, logic last, logic err);
            pixel_t want;
            if (owed_pixels.size() == 0) begin
                report($sformatf("unexpected item color %06h last %0b error %0b",
                                 color, last, err));
                return;
            end
            want = owed_pixels.pop_front();
            if (color !== want.color)
                report($sformatf("color %06h, want %06h", color, want.color));
            if (last !== want.last)
                report($sformatf("last pixel flag %0b, want %0b", last, want.last));
            if (err !== want.err)
                report($sformatf("code error flag %0b, want %0b", err, want.err));
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    pixel_tracker tracker;
    bit           src_rush;
    bit           snk_rush;

    huffman_pixel_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Both channels sampled on pre-edge values
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            tracker.absorb_item(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready)
            tracker.check_pixel(m_tdata, m_tlast, m_tuser[0]);
    end

    // Result side: random stall before each item, with runs of no stalls
    initial begin : result_sink
        int unsigned hold;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 24) == 0) snk_rush = !snk_rush;
            hold = snk_rush ? 0 : $urandom_range(0, 16);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // Run limit
    initial begin
        #50_000_000;
        $display("tb_huffman_pixel_decoder failed");
        $finish;
    end

    // Random filler; top zero-fill bits kept clear
    function automatic logic [S_TDATA_W-1:0] junk_word();
        return {3'b000, 29'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [S_TDATA_W-1:0] load_word(input logic [INDEX_W-1:0] idx,
                                                       input logic [CODE_W-1:0] code,
                                                       input logic [LENGTH_W-1:0] len,
                                                       input logic [COLOR_W-1:0] color);
        logic [S_TDATA_W-1:0] w;
        w        = junk_word();
        w[7:0]   = idx;
        w[23:8]  = code;
        w[28:24] = len;
        w[52:29] = color;
        return w;
    endfunction

    function automatic logic [S_TDATA_W-1:0] byte_word(input logic [BYTE_W-1:0] bv);
        logic [S_TDATA_W-1:0] w;
        w         = junk_word();
        w[60:53]  = bv;
        return w;
    endfunction

    // Offer one item after a random gap and wait for it to be taken
    task automatic push_item(input kind_t k, input logic [S_TDATA_W-1:0] word);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) src_rush = !src_rush;
        gap = src_rush ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Write a register, then read it back
    task automatic reg_write(input reg_idx_t r, input logic [APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        tracker.set_dim(r, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== v)
            tracker.report($sformatf("register %s reads %0d, want %0d", r.name(), prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_image(input int unsigned w, input int unsigned h);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    // Stop sending, let every owed pixel arrive and the block run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        // let the last accepted item be noted first
        @(posedge aclk);
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int                fed;
        int                i;
        int                j;
        int                s;
        int                count;
        int                cur;
        int                prev;
        int                budget;
        int                base;
        int                stride;
        int                nsym_out;
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] cmask;
        logic [CODE_W-1:0] sym_code [16];
        int                sym_len  [16];
        logic [BYTE_W-1:0] bv;
        bit                bits [$];

        tracker  = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_CLEAR;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 15 pixel image
        set_image(3, 5);
        push_item(KIND_UNUSED, {3'b000, {61{1'b1}}});
        push_item(KIND_CLEAR, junk_word());
        push_item(KIND_LOAD, load_word(8'd0, 16'hFFFE, 5'd1, 24'hFFFFFF));
        push_item(KIND_LOAD, load_word(8'd255, 16'hFFFF, 5'd16, 24'h000000));
        push_item(KIND_LOAD, load_word(8'd1, 16'h0002, 5'd2, 24'h123456));
        // same code in a higher slot: lower slot must win
        push_item(KIND_LOAD, load_word(8'd2, 16'h0002, 5'd2, 24'hABCDEF));
        // lengths that can never match
        push_item(KIND_LOAD, load_word(8'd3, 16'h0000, 5'd0, 24'h111111));
        push_item(KIND_LOAD, load_word(8'd4, 16'h0000, 5'd20, 24'h222222));
        push_item(KIND_LOAD, load_word(8'd5, 16'h0001, 5'd31, 24'h333333));
        push_item(KIND_DATA, byte_word(8'h80));
        // reload: slot 1 now 110, so 10 falls to slot 2
        push_item(KIND_LOAD, load_word(8'd1, 16'hFF06, 5'd3, 24'h00FF00));
        push_item(KIND_DATA, byte_word(8'hA5));
        push_item(KIND_DATA, byte_word(8'hFF));
        push_item(KIND_DATA, byte_word(8'hFF));
        // image completes inside this byte; padding and the next byte ignored
        push_item(KIND_DATA, byte_word(8'h00));
        push_item(KIND_DATA, byte_word(8'h3C));
        push_item(KIND_UNUSED, junk_word());
        // sixteen bits with no match give an error item
        push_item(KIND_CLEAR, junk_word());
        push_item(KIND_LOAD, load_word(8'd7, 16'h0001, 5'd16, 24'h5A5A5A));
        push_item(KIND_DATA, byte_word(8'h00));
        push_item(KIND_DATA, byte_word(8'h00));
        push_item(KIND_DATA, byte_word(8'h00));
        push_item(KIND_DATA, byte_word(8'h01));
        settle();
        // zero register: nothing may come out
        set_image(0, 7);
        push_item(KIND_DATA, byte_word(8'h00));
        push_item(KIND_DATA, byte_word(8'h01));

        // Random frames: set-up, clear, prefix-free table, encoded pixels, some noise
        fed = 0;
        while (fed < RANDOM_ITEMS) begin
            settle();
            if ($urandom_range(0, 9) == 0 && tracker.emitted != 0) begin
                // limit lowered to or below the pixels already out
                set_image(1, (tracker.emitted > 4096) ? 4096
                                                       : $urandom_range(1, tracker.emitted));
                repeat ($urandom_range(2, 5)) begin
                    push_item(KIND_DATA, byte_word(BYTE_W'($urandom_range(0, 255))));
                    fed++;
                end
                continue;
            end
            case ($urandom_range(0, 7))
                0:       set_image(1, 1);
                1:       set_image(4096, 4096);
                2:       set_image(4096, 1);
                3:       set_image(1, 4096);
                4:       set_image($urandom_range(1, 4096), $urandom_range(1, 4096));
                default: set_image($urandom_range(1, 6), $urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 7) != 0) begin
                push_item(KIND_CLEAR, junk_word());
                fed++;
            end

            // canonical code, lengths ascending within the Kraft budget
            budget = 1 << MAX_CODE_LEN_DEF;
            cur    = $urandom_range(1, 4);
            prev   = cur;
            code   = '0;
            count  = 0;
            for (i = 0; i < $urandom_range(1, 16); i++) begin
                if (i != 0)
                    cur += ($urandom_range(0, 5) == 0) ? $urandom_range(2, 8)
                                                       : $urandom_range(0, 1);
                while (cur <= MAX_CODE_LEN_DEF && (1 << (MAX_CODE_LEN_DEF - cur)) > budget)
                    cur++;
                if (cur > MAX_CODE_LEN_DEF) break;
                if (i != 0) code = (code + 1'b1) << (cur - prev);
                sym_code[i] = code;
                sym_len[i]  = cur;
                budget     -= 1 << (MAX_CODE_LEN_DEF - cur);
                prev        = cur;
                count++;
            end

            // load into distinct slots, junk above the code bits
            base   = $urandom_range(0, 255);
            stride = 2 * $urandom_range(0, 127) + 1;
            for (i = 0; i < count; i++) begin
                cmask = CODE_W'((33'd1 << sym_len[i]) - 1);
                push_item(KIND_LOAD, load_word(INDEX_W'((base + i * stride) % SLOT_LIMIT),
                                               (CODE_W'($urandom) & ~cmask) | sym_code[i],
                                               LENGTH_W'(sym_len[i]),
                                               COLOR_W'($urandom_range(0, 24'hFFFFFF))));
                fed++;
                if ($urandom_range(0, 11) == 0) push_item(KIND_UNUSED, junk_word());
            end
            if ($urandom_range(0, 7) == 0) begin
                push_item(KIND_LOAD, junk_word());
                fed++;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(2, 6)) begin
                    push_item(KIND_DATA, byte_word(BYTE_W'($urandom_range(0, 255))));
                    fed++;
                end
            end

            // encode random pixels, now and then a run of stray bits
            bits.delete();
            nsym_out = $urandom_range(3, 20);
            for (i = 0; i < nsym_out && bits.size() < 160; i++) begin
                if ($urandom_range(0, 15) == 0)
                    repeat ($urandom_range(1, 12))
                        bits.insert(bits.size(), 1'($urandom_range(0, 1)));
                s = $urandom_range(0, count - 1);
                for (j = sym_len[s] - 1; j >= 0; j--) bits.insert(bits.size(), sym_code[s][j]);
            end
            while (bits.size() % 8 != 0) bits.insert(bits.size(), 1'($urandom_range(0, 1)));
            for (i = 0; i < bits.size(); i += 8) begin
                bv = '0;
                for (j = 0; j < 8; j++) bv = {bv[6:0], bits[i + j]};
                push_item(KIND_DATA, byte_word(bv));
                fed++;
                if ($urandom_range(0, 15) == 0) push_item(KIND_UNUSED, junk_word());
            end
        end

        settle();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb_huffman_pixel_decoder passed");
        else
            $display("tb_huffman_pixel_decoder failed");
        $finish;
    end

endmodule
